// ===== hw/rtl/tcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants of the tiny control unit
// Word layouts of both channels, command and opcode codes, store sizes and
// the sequencer state type.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Field widths.
  localparam int CMD_W  = 2;
  localparam int ADDR_W = 11;
  localparam int DATA_W = 8;
  localparam int OP_W   = 5;
  localparam int OPND_W = 11;
  localparam int INSN_W = OP_W + OPND_W;

  // Store sizes. Both are powers of two, so an index is a plain bit-select.
  localparam int MEM_DEPTH = 2048;
  localparam int IO_DEPTH  = 32;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int IO_AW     = $clog2(IO_DEPTH);

  // Commands carried in the cmd field.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD      = 2'd0,
    CMD_STEP      = 2'd1,
    CMD_PEEK_MAIN = 2'd2,
    CMD_PEEK_IO   = 2'd3
  } tcc_cmd_e;

  // Opcodes that do something beyond the fetch.
  localparam logic [OP_W-1:0] OP_WM  = 5'h01;
  localparam logic [OP_W-1:0] OP_RM  = 5'h02;
  localparam logic [OP_W-1:0] OP_BR  = 5'h03;
  localparam logic [OP_W-1:0] OP_RIO = 5'h04;
  localparam logic [OP_W-1:0] OP_WIO = 5'h05;
  localparam logic [OP_W-1:0] OP_WB  = 5'h06;
  localparam logic [OP_W-1:0] OP_WIB = 5'h07;
  localparam logic [OP_W-1:0] OP_EOP = 5'h1F;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH_LO,
    ST_EXEC,
    ST_DATA,
    ST_DONE
  } tcc_state_e;

  // Input word.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } tcc_in_t;

  // Result word.
  typedef struct packed {
    logic [ADDR_W-1:0] pc_now;
    logic [OP_W-1:0]   opcode;
    logic [OPND_W-1:0] operand_field;
    logic [DATA_W-1:0] mbr_now;
    logic [DATA_W-1:0] iobr_now;
    logic [DATA_W-1:0] read_data;
    logic              executed;
    logic              halted;
  } tcc_out_t;

endpackage

// ===== hw/rtl/tiny_cpu_control_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_cpu_control_unit: minimal fetch and execute control unit
// Fetches big-endian 16-bit instructions from a byte-wide main store and
// executes them against MBR, IOBR, the main store and a small I/O store.
// Load and peek commands give direct access to both stores.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Word
//   in        sink       in_valid_i/in_stall_o   tcc_pkg::tcc_in_t
//   out       source     out_valid_o/out_stall_i tcc_pkg::tcc_out_t
//
// Loads and peeks go straight to ST_DONE, so they can follow every cycle while the
// output is not stalled. A step passes ST_FETCH_LO and ST_EXEC (two byte fetches
// through the single main-store read port, then execute); RM and RIO also pass
// ST_DATA for one more store read. A result is registered as the sequencer finishes,
// in the cycle that takes the next word. Reset clears PC, MBR, IOBR, the halt flag
// and the I/O store valid bits. Only a second result stalls behind a stalled output.
// ----------------------------------------------------------------------------
module tiny_cpu_control_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tcc_pkg::tcc_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tcc_pkg::tcc_out_t  out_data_o
);

  // --------------------------------------------------------------------------
  // Architectural registers and sequencer state.
  // --------------------------------------------------------------------------
  tcc_pkg::tcc_state_e state_q, state_d;

  logic [tcc_pkg::ADDR_W-1:0] pc_q;
  logic [tcc_pkg::DATA_W-1:0] mbr_q;
  logic [tcc_pkg::DATA_W-1:0] iobr_q;
  logic                       halt_q;

  // Per-word working registers.
  tcc_pkg::tcc_cmd_e          cmd_q;
  logic [tcc_pkg::DATA_W-1:0] hi_q;
  logic [tcc_pkg::OP_W-1:0]   op_q;
  logic [tcc_pkg::OPND_W-1:0] operand_q;
  logic                       ran_q;

  // Output register.
  tcc_pkg::tcc_out_t out_q;
  logic              out_valid_q;

  // --------------------------------------------------------------------------
  // Handshake. A word is taken when the sequencer is idle, or when it is
  // handing its result to a free output register in the same cycle.
  // --------------------------------------------------------------------------
  logic              out_free;
  logic              accept;
  tcc_pkg::tcc_cmd_e in_cmd;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == tcc_pkg::ST_IDLE) ||
                        ((state_q == tcc_pkg::ST_DONE) && out_free));
  assign accept     = in_valid_i && !in_stall_o;
  assign in_cmd     = tcc_pkg::tcc_cmd_e'(in_data_i.cmd);

  // The instruction word is complete in ST_EXEC: the high byte was latched
  // into hi_q in ST_FETCH_LO and the low byte sits in the main-store read register.
  logic [tcc_pkg::DATA_W-1:0] mem_rd_q;
  logic [tcc_pkg::INSN_W-1:0] insn;
  logic [tcc_pkg::OP_W-1:0]   ex_op;
  logic [tcc_pkg::OPND_W-1:0] ex_operand;

  assign insn       = {hi_q, mem_rd_q};
  assign ex_op      = insn[tcc_pkg::INSN_W-1 -: tcc_pkg::OP_W];
  assign ex_operand = insn[tcc_pkg::OPND_W-1:0];

  // --------------------------------------------------------------------------
  // Next-state logic.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcc_pkg::ST_IDLE, tcc_pkg::ST_DONE: begin
        if (state_q == tcc_pkg::ST_DONE && out_free) begin
          state_d = tcc_pkg::ST_IDLE;
        end
        if (accept) begin
          if (in_cmd == tcc_pkg::CMD_STEP && !halt_q) begin
            state_d = tcc_pkg::ST_FETCH_LO;
          end else begin
            state_d = tcc_pkg::ST_DONE;
          end
        end
      end
      tcc_pkg::ST_FETCH_LO: state_d = tcc_pkg::ST_EXEC;
      tcc_pkg::ST_EXEC: begin
        if (ex_op == tcc_pkg::OP_RM || ex_op == tcc_pkg::OP_RIO) begin
          state_d = tcc_pkg::ST_DATA;
        end else begin
          state_d = tcc_pkg::ST_DONE;
        end
      end
      tcc_pkg::ST_DATA: state_d = tcc_pkg::ST_DONE;
      default: state_d = tcc_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Store access decode. Each word runs alone through the sequencer, so a
  // write and a later read of the same entry never overlap in flight.
  // --------------------------------------------------------------------------
  logic                       mem_re;
  logic [tcc_pkg::MEM_AW-1:0] mem_raddr;
  logic                       mem_we;
  logic [tcc_pkg::MEM_AW-1:0] mem_waddr;
  logic [tcc_pkg::DATA_W-1:0] mem_wdata;
  logic                       io_re;
  logic [tcc_pkg::IO_AW-1:0]  io_raddr;
  logic                       io_we;
  logic [tcc_pkg::IO_AW-1:0]  io_waddr;
  logic                       out_load;
  logic [tcc_pkg::ADDR_W-1:0] pc_plus1;

  assign pc_plus1 = pc_q + tcc_pkg::ADDR_W'(1);

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = pc_q[tcc_pkg::MEM_AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = in_data_i.addr[tcc_pkg::MEM_AW-1:0];
    mem_wdata = in_data_i.data;
    io_re     = 1'b0;
    io_raddr  = in_data_i.addr[tcc_pkg::IO_AW-1:0];
    io_we     = 1'b0;
    io_waddr  = ex_operand[tcc_pkg::IO_AW-1:0];
    out_load  = 1'b0;
    unique case (state_q)
      tcc_pkg::ST_IDLE, tcc_pkg::ST_DONE: begin
        out_load = (state_q == tcc_pkg::ST_DONE) && out_free;
        if (accept) begin
          unique case (in_cmd)
            tcc_pkg::CMD_LOAD: mem_we = 1'b1;
            tcc_pkg::CMD_STEP: begin
              // Fetch the high byte at PC.
              mem_re = !halt_q;
            end
            tcc_pkg::CMD_PEEK_MAIN: begin
              mem_re    = 1'b1;
              mem_raddr = in_data_i.addr[tcc_pkg::MEM_AW-1:0];
            end
            tcc_pkg::CMD_PEEK_IO: io_re = 1'b1;
            default: ;
          endcase
        end
      end
      tcc_pkg::ST_FETCH_LO: begin
        mem_re    = 1'b1;
        mem_raddr = pc_plus1[tcc_pkg::MEM_AW-1:0];
      end
      tcc_pkg::ST_EXEC: begin
        mem_waddr = ex_operand[tcc_pkg::MEM_AW-1:0];
        mem_wdata = mbr_q;
        mem_raddr = ex_operand[tcc_pkg::MEM_AW-1:0];
        io_raddr  = ex_operand[tcc_pkg::IO_AW-1:0];
        mem_we    = (ex_op == tcc_pkg::OP_WM);
        mem_re    = (ex_op == tcc_pkg::OP_RM);
        io_re     = (ex_op == tcc_pkg::OP_RIO);
        io_we     = (ex_op == tcc_pkg::OP_WIO);
      end
      tcc_pkg::ST_DATA: ;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Main store: one write port, one registered read port.
  // --------------------------------------------------------------------------
  logic [tcc_pkg::DATA_W-1:0] main_mem [tcc_pkg::MEM_DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      main_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_q <= main_mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // I/O store: reset to zero through one valid bit per entry; an entry that
  // was never written reads as zero.
  // --------------------------------------------------------------------------
  logic [tcc_pkg::DATA_W-1:0] io_mem [tcc_pkg::IO_DEPTH];
  logic [tcc_pkg::IO_DEPTH-1:0] io_vld_q;
  logic [tcc_pkg::DATA_W-1:0] io_rd_q;
  logic                       io_rd_vld_q;
  logic [tcc_pkg::DATA_W-1:0] io_value;

  always_ff @(posedge clk_i) begin
    if (io_we) begin
      io_mem[io_waddr] <= iobr_q;
    end
    if (io_re) begin
      io_rd_q     <= io_mem[io_raddr];
      io_rd_vld_q <= io_vld_q[io_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      io_vld_q <= '0;
    end else if (io_we) begin
      io_vld_q[io_waddr] <= 1'b1;
    end
  end

  assign io_value = io_rd_vld_q ? io_rd_q : '0;

  // --------------------------------------------------------------------------
  // Architectural registers and sequencer state.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcc_pkg::ST_IDLE;
      pc_q    <= '0;
      mbr_q   <= '0;
      iobr_q  <= '0;
      halt_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tcc_pkg::ST_EXEC) begin
        if (ex_op == tcc_pkg::OP_BR) begin
          pc_q <= ex_operand;
        end else begin
          pc_q <= pc_q + tcc_pkg::ADDR_W'(2);
        end
        if (ex_op == tcc_pkg::OP_WB) begin
          mbr_q <= ex_operand[tcc_pkg::DATA_W-1:0];
        end
        if (ex_op == tcc_pkg::OP_WIB) begin
          iobr_q <= ex_operand[tcc_pkg::DATA_W-1:0];
        end
        if (ex_op == tcc_pkg::OP_EOP) begin
          halt_q <= 1'b1;
        end
      end
      if (state_q == tcc_pkg::ST_DATA) begin
        if (op_q == tcc_pkg::OP_RM) begin
          mbr_q <= mem_rd_q;
        end else begin
          iobr_q <= io_value;
        end
      end
    end
  end

  // Per-word working registers: cleared on accept so that commands that do
  // not execute report a zero opcode and operand.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= in_cmd;
      op_q      <= '0;
      operand_q <= '0;
      ran_q     <= 1'b0;
    end
    if (state_q == tcc_pkg::ST_FETCH_LO) begin
      hi_q <= mem_rd_q;
    end
    if (state_q == tcc_pkg::ST_EXEC) begin
      op_q      <= ex_op;
      operand_q <= ex_operand;
      ran_q     <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  logic [tcc_pkg::DATA_W-1:0] peek_data;

  always_comb begin
    case (cmd_q)
      tcc_pkg::CMD_PEEK_MAIN: peek_data = mem_rd_q;
      tcc_pkg::CMD_PEEK_IO:   peek_data = io_value;
      default:                peek_data = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.pc_now        <= pc_q;
      out_q.opcode        <= op_q;
      out_q.operand_field <= operand_q;
      out_q.mbr_now       <= mbr_q;
      out_q.iobr_now      <= iobr_q;
      out_q.read_data     <= peek_data;
      out_q.executed      <= ran_q;
      out_q.halted        <= halt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/sv/tb_tiny_cpu_control_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tiny_cpu_control_unit: self-checking bench for the tiny control unit
// Drives load, step and peek words into the block and keeps a shadow copy of
// PC, MBR, IOBR, the halt flag and both stores. Every result word is checked
// field by field against the shadow. A short directed table comes first, then
// random programs, and a halt sequence closes the run.
// ----------------------------------------------------------------------------
module tb_tiny_cpu_control_unit;

  // One row of the directed table. Where typed is set, want is the result
  // that the block must return. Otherwise the shadow machine decides.
  typedef struct packed {
    tcc_pkg::tcc_cmd_e          cmd;
    logic [tcc_pkg::ADDR_W-1:0] addr;
    logic [tcc_pkg::DATA_W-1:0] data;
    bit                         typed;
    tcc_pkg::tcc_out_t          want;
  } dir_row_t;

  localparam tcc_pkg::tcc_out_t ZERO_RESULT = '0;
  localparam int DIR_ROWS = 25;

  // The directed program runs every opcode but EOP, and BR twice. Instructions are stored
  // big-endian: the high byte at the even address and the low byte after it.
  // It ends with a branch to the last byte of the store, so the final fetch
  // takes its high byte at address 2047 and its low byte at address 0.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{tcc_pkg::CMD_PEEK_IO,   11'h7FF, 8'hA5, 1'b1, ZERO_RESULT},   // I/O store is clear
    '{tcc_pkg::CMD_LOAD,      11'h000, 8'h30, 1'b1, ZERO_RESULT},   // WB 0x0FF
    '{tcc_pkg::CMD_LOAD,      11'h001, 8'hFF, 1'b1, ZERO_RESULT},
    '{tcc_pkg::CMD_STEP,      11'h5A5, 8'h5A, 1'b1,
      '{11'd2, tcc_pkg::OP_WB, 11'h0FF, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b0}},
    '{tcc_pkg::CMD_LOAD,      11'h002, 8'h3F, 1'b0, ZERO_RESULT},   // WIB 0x7FF
    '{tcc_pkg::CMD_LOAD,      11'h003, 8'hFF, 1'b0, ZERO_RESULT},
    '{tcc_pkg::CMD_STEP,      11'h2AA, 8'h00, 1'b0, ZERO_RESULT},
    '{tcc_pkg::CMD_LOAD,      11'h004, 8'h2F, 1'b0, ZERO_RESULT},   // WIO to I/O byte 31
    '{tcc_pkg::CMD_LOAD,      11'h005, 8'hFF, 1'b0, ZERO_RESULT},
    '{tcc_pkg::CMD_STEP,      11'h7FF, 8'hFF, 1'b0, ZERO_RESULT},
    '{tcc_pkg::CMD_LOAD,      11'h006, 8'h0F, 1'b0, ZERO_RESULT},   // WM to byte 2047
    '{tcc_pkg::CMD_LOAD,      11'h007, 8'hFF, 1'b0, ZERO_RESULT},
    '{tcc_pkg::CMD_STEP,      11'h000, 8'h00, 1'b0, ZERO_RESULT},
    '{tcc_pkg::CMD_LOAD,      11'h008, 8'h10, 1'b0, ZERO_RESULT},   // RM from byte 0
    '{tcc_pkg::CMD_LOAD,      11'h009, 8'h00, 1'b0, ZERO_RESULT},
    '{tcc_pkg::CMD_STEP,      11'h555, 8'hAA, 1'b0, ZERO_RESULT},
    '{tcc_pkg::CMD_LOAD,      11'h00A, 8'h27, 1'b0, ZERO_RESULT},   // RIO, operand 0x7E0
    '{tcc_pkg::CMD_LOAD,      11'h00B, 8'hE0, 1'b0, ZERO_RESULT},
    '{tcc_pkg::CMD_STEP,      11'h0F0, 8'h0F, 1'b0, ZERO_RESULT},
    '{tcc_pkg::CMD_LOAD,      11'h00C, 8'h1F, 1'b0, ZERO_RESULT},   // BR 0x7FF
    '{tcc_pkg::CMD_LOAD,      11'h00D, 8'hFF, 1'b0, ZERO_RESULT},
    '{tcc_pkg::CMD_STEP,      11'h3C3, 8'hC3, 1'b0, ZERO_RESULT},
    '{tcc_pkg::CMD_PEEK_MAIN, 11'h7FF, 8'h00, 1'b0, ZERO_RESULT},   // MBR stored by WM
    '{tcc_pkg::CMD_LOAD,      11'h7FF, 8'h18, 1'b0, ZERO_RESULT},   // BR across the wrap
    '{tcc_pkg::CMD_STEP,      11'h100, 8'h80, 1'b0, ZERO_RESULT}
  };

  logic              clk_i = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  tcc_pkg::tcc_in_t  in_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  tcc_pkg::tcc_out_t out_word;

  tiny_cpu_control_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow machine. main_seen marks the main store bytes that hold a known
  // value; the stimulus never lets the block read any other byte.
  logic [tcc_pkg::ADDR_W-1:0] cpu_pc = '0;
  logic [tcc_pkg::DATA_W-1:0] cpu_mbr = '0;
  logic [tcc_pkg::DATA_W-1:0] cpu_iobr = '0;
  bit                         cpu_halted = 1'b0;
  logic [tcc_pkg::DATA_W-1:0] main_mem [tcc_pkg::MEM_DEPTH];
  bit                         main_seen [tcc_pkg::MEM_DEPTH];
  logic [tcc_pkg::DATA_W-1:0] io_mem [tcc_pkg::IO_DEPTH];
  int                         seen_list [$];

  tcc_pkg::tcc_out_t pending_results [$];
  int                words_sent = 0;
  int                mismatches = 0;
  bit                calm = 1'b0;
  int                stall_left = 0;

  initial begin
    foreach (main_seen[i]) main_seen[i] = 1'b0;
    foreach (io_mem[i]) io_mem[i] = '0;
  end

  function automatic void store_main(logic [tcc_pkg::ADDR_W-1:0] a,
                                     logic [tcc_pkg::DATA_W-1:0] d);
    main_mem[a] = d;
    if (!main_seen[a]) begin
      main_seen[a] = 1'b1;
      seen_list.push_back(int'(a));
    end
  endfunction

  // Applies one input word to the shadow machine and returns its result.
  function automatic tcc_pkg::tcc_out_t execute_word(tcc_pkg::tcc_in_t w);
    tcc_pkg::tcc_out_t r;
    logic [tcc_pkg::INSN_W-1:0] insn;
    r = '0;
    case (tcc_pkg::tcc_cmd_e'(w.cmd))
      tcc_pkg::CMD_LOAD: begin
        store_main(w.addr, w.data);
      end
      tcc_pkg::CMD_PEEK_MAIN: begin
        r.read_data = main_mem[w.addr];
      end
      tcc_pkg::CMD_PEEK_IO: begin
        r.read_data = io_mem[w.addr[tcc_pkg::IO_AW-1:0]];
      end
      default: begin
        // A halted machine ignores steps entirely: no fetch, no decode.
        if (!cpu_halted) begin
          insn = {main_mem[cpu_pc], main_mem[cpu_pc + 11'd1]};
          cpu_pc = cpu_pc + 11'd2;
          r.opcode = insn[tcc_pkg::INSN_W-1:tcc_pkg::OPND_W];
          r.operand_field = insn[tcc_pkg::OPND_W-1:0];
          r.executed = 1'b1;
          case (r.opcode)
            tcc_pkg::OP_WM:  store_main(r.operand_field, cpu_mbr);
            tcc_pkg::OP_RM:  cpu_mbr = main_mem[r.operand_field];
            tcc_pkg::OP_BR:  cpu_pc = r.operand_field;
            tcc_pkg::OP_RIO: cpu_iobr = io_mem[r.operand_field[tcc_pkg::IO_AW-1:0]];
            tcc_pkg::OP_WIO: io_mem[r.operand_field[tcc_pkg::IO_AW-1:0]] = cpu_iobr;
            tcc_pkg::OP_WB:  cpu_mbr = r.operand_field[tcc_pkg::DATA_W-1:0];
            tcc_pkg::OP_WIB: cpu_iobr = r.operand_field[tcc_pkg::DATA_W-1:0];
            tcc_pkg::OP_EOP: cpu_halted = 1'b1;
            default: ;
          endcase
        end
      end
    endcase
    r.pc_now = cpu_pc;
    r.mbr_now = cpu_mbr;
    r.iobr_now = cpu_iobr;
    r.halted = cpu_halted;
    return r;
  endfunction

  // Idle length for either side: mostly none, sometimes a short one, and
  // now and then a long pause. Calm stretches run with no idling at all.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic tcc_pkg::tcc_in_t make_word(tcc_pkg::tcc_cmd_e c,
                                                 logic [tcc_pkg::ADDR_W-1:0] a,
                                                 logic [tcc_pkg::DATA_W-1:0] d);
    tcc_pkg::tcc_in_t w;
    w.cmd = c;
    w.addr = a;
    w.data = d;
    return w;
  endfunction

  // Records the expected result, then presents the word from a falling edge
  // and holds it until a rising edge sees valid without stall. Returns at the
  // falling edge after acceptance, so a following word with no gap keeps
  // valid high without a drop.
  task automatic send_word(input tcc_pkg::tcc_in_t w, input bit typed = 1'b0,
                           input tcc_pkg::tcc_out_t want = '0);
    tcc_pkg::tcc_out_t predicted;
    int gap;
    predicted = execute_word(w);
    pending_results.push_back(typed ? want : predicted);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_word = w;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Issues one step. While running, the two instruction bytes at PC are made
  // known first: either an already stored instruction is reused, when it is
  // safe to run, or a fresh one is loaded. An RM operand always points at a
  // known byte. Halt is only loaded when halt_now asks for it.
  task automatic run_step(input bit halt_now);
    logic [tcc_pkg::ADDR_W-1:0] pc_lo;
    logic [tcc_pkg::OPND_W-1:0] opnd;
    logic [tcc_pkg::OP_W-1:0]   op;
    logic [tcc_pkg::INSN_W-1:0] insn;
    bit reuse;
    if (!cpu_halted) begin
      pc_lo = cpu_pc + 11'd1;
      insn = {main_mem[cpu_pc], main_mem[pc_lo]};
      reuse = !halt_now && main_seen[cpu_pc] && main_seen[pc_lo] &&
              insn[tcc_pkg::INSN_W-1:tcc_pkg::OPND_W] != tcc_pkg::OP_EOP &&
              (insn[tcc_pkg::INSN_W-1:tcc_pkg::OPND_W] != tcc_pkg::OP_RM ||
               main_seen[insn[tcc_pkg::OPND_W-1:0]]) &&
              $urandom_range(0, 1) == 1;
      if (!reuse) begin
        if (halt_now) op = tcc_pkg::OP_EOP;
        else if ($urandom_range(0, 9) < 2) op = tcc_pkg::OP_W'($urandom_range(8, 30));
        else op = tcc_pkg::OP_W'($urandom_range(0, 7));
        opnd = tcc_pkg::OPND_W'($urandom_range(0, 2047));
        if (op == tcc_pkg::OP_RM) begin
          if (seen_list.size() != 0 && $urandom_range(0, 1) == 1)
            opnd = tcc_pkg::OPND_W'(seen_list[$urandom_range(0, seen_list.size() - 1)]);
          else if (!main_seen[opnd])
            send_word(make_word(tcc_pkg::CMD_LOAD, opnd,
                                tcc_pkg::DATA_W'($urandom_range(0, 255))));
        end
        insn = {op, opnd};
        send_word(make_word(tcc_pkg::CMD_LOAD, cpu_pc,
                            insn[tcc_pkg::INSN_W-1:tcc_pkg::DATA_W]));
        send_word(make_word(tcc_pkg::CMD_LOAD, pc_lo, insn[tcc_pkg::DATA_W-1:0]));
      end
    end
    send_word(make_word(tcc_pkg::CMD_STEP, tcc_pkg::ADDR_W'($urandom_range(0, 2047)),
                        tcc_pkg::DATA_W'($urandom_range(0, 255))));
  endtask

  // One random action chosen by kind: mostly steps, then loads and peeks.
  // Main store peeks only go to bytes that hold a known value.
  task automatic random_action(input int kind);
    if (kind < 60) begin
      run_step(1'b0);
    end else if (kind < 75 || seen_list.size() == 0) begin
      send_word(make_word(tcc_pkg::CMD_LOAD, tcc_pkg::ADDR_W'($urandom_range(0, 2047)),
                          tcc_pkg::DATA_W'($urandom_range(0, 255))));
    end else if (kind < 90) begin
      send_word(make_word(tcc_pkg::CMD_PEEK_MAIN,
                          tcc_pkg::ADDR_W'(seen_list[$urandom_range(0,
                                                     seen_list.size() - 1)]),
                          tcc_pkg::DATA_W'($urandom_range(0, 255))));
    end else begin
      send_word(make_word(tcc_pkg::CMD_PEEK_IO, tcc_pkg::ADDR_W'($urandom_range(0, 2047)),
                          tcc_pkg::DATA_W'($urandom_range(0, 255))));
    end
  endtask

  // Receiver side: stall in bursts of random length, changed at the falling
  // edge only, and always dropped again between bursts.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      stall_left = pick_gap();
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Every result word taken at a rising edge is compared with the oldest
  // expectation. The values read here are those from before the edge.
  always @(posedge clk_i) begin : result_check
    tcc_pkg::tcc_out_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with nothing expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("pc_now", 16'(want.pc_now), 16'(out_word.pc_now));
        check_field("opcode", 16'(want.opcode), 16'(out_word.opcode));
        check_field("operand_field", 16'(want.operand_field),
                    16'(out_word.operand_field));
        check_field("mbr_now", 16'(want.mbr_now), 16'(out_word.mbr_now));
        check_field("iobr_now", 16'(want.iobr_now), 16'(out_word.iobr_now));
        check_field("read_data", 16'(want.read_data), 16'(out_word.read_data));
        check_field("executed", 16'(want.executed), 16'(out_word.executed));
        check_field("halted", 16'(want.halted), 16'(out_word.halted));
      end
    end
  end

  initial begin : stimulus
    int kind;
    int burst;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i])
      send_word(make_word(DIRECTED[i].cmd, DIRECTED[i].addr, DIRECTED[i].data),
                DIRECTED[i].typed, DIRECTED[i].want);

    // Random bursts of one kind each. Halt stays out of this part, because
    // only reset could wake the machine again.
    while (words_sent < 830) begin
      calm = ($urandom_range(0, 9) == 0);
      kind = $urandom_range(0, 99);
      burst = $urandom_range(1, 6);
      repeat (burst) random_action(kind);
    end

    // Closing sequence: execute halt, then steps, loads and peeks while
    // halted. Steps now must leave everything as it is.
    calm = 1'b0;
    run_step(1'b1);
    repeat (20) random_action($urandom_range(0, 99));

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // About 850 words, plus the longest gaps on both sides, stay under one
  // millisecond. The limit is several times that.
  initial begin : watchdog
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
